@@ hw/rtl/rgbc_pkg.sv @@
// shared constants and types of the rgb 3x3 convolution block
package rgbc_pkg;

  localparam int MAX_WIDTH    = 1024;
  localparam int ADDR_W       = $clog2(MAX_WIDTH);
  localparam int WEFF_W       = $clog2(MAX_WIDTH + 1);
  localparam int MAX_HEIGHT   = 4096;
  localparam int WIDTH_REG_W  = 11;
  localparam int HEIGHT_REG_W = 13;
  localparam int ROW_W        = 13;

  localparam int COEF_BITS = 16;
  localparam int FRAC_BITS = 8;
  localparam int KERNEL_W  = 3 * COEF_BITS;

  localparam int CHAN_W   = 8;
  localparam int PIX_W    = 3 * CHAN_W;
  localparam int CHAN_MAX = 255;

  localparam int PROD_W = COEF_BITS + CHAN_W + 1;
  localparam int COL_W  = PROD_W + 2;
  localparam int SUM_W  = PROD_W + 4;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = KERNEL_W;

  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = FIFO_AW + 2;

  localparam logic [WIDTH_REG_W-1:0]  FRAME_WIDTH_RESET  = WIDTH_REG_W'(1024);
  localparam logic [HEIGHT_REG_W-1:0] FRAME_HEIGHT_RESET = HEIGHT_REG_W'(1);
  localparam logic [KERNEL_W-1:0]     KERNEL_MID_RESET   =
    KERNEL_W'(1) << (COEF_BITS + FRAC_BITS);

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_FRAME_WIDTH   = 3'd0,
    REG_FRAME_HEIGHT  = 3'd1,
    REG_KERNEL_TOP    = 3'd2,
    REG_KERNEL_MIDDLE = 3'd3,
    REG_KERNEL_BOTTOM = 3'd4
  } cfg_reg_t;

  typedef enum logic {
    CMD_PIXEL = 1'b0,
    CMD_FLUSH = 1'b1
  } cmd_t;

  // per-transaction control carried down the pipeline
  typedef struct packed {
    logic res;
    logic last;
    logic left_zero;
    logic right_zero;
  } tap_ctrl_t;

  typedef struct packed {
    logic              last;
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] red;
  } out_item_t;

endpackage

@@ hw/rtl/rgbc_in_if.sv @@
// input pixel channel: valid/ready handshake with pixel payload
interface rgbc_in_if;
  logic                      valid;
  logic                      ready;
  logic                      cmd;
  logic [rgbc_pkg::CHAN_W-1:0] pixel_red;
  logic [rgbc_pkg::CHAN_W-1:0] pixel_green;
  logic [rgbc_pkg::CHAN_W-1:0] pixel_blue;

  modport source (output valid, cmd, pixel_red, pixel_green, pixel_blue, input ready);
  modport sink (input valid, cmd, pixel_red, pixel_green, pixel_blue, output ready);
endinterface

@@ hw/rtl/rgbc_out_if.sv @@
// output pixel channel: valid/ready handshake with filtered payload
interface rgbc_out_if;
  logic                      valid;
  logic                      ready;
  logic [rgbc_pkg::CHAN_W-1:0] out_red;
  logic [rgbc_pkg::CHAN_W-1:0] out_green;
  logic [rgbc_pkg::CHAN_W-1:0] out_blue;
  logic                      out_last;

  modport source (output valid, out_red, out_green, out_blue, out_last, input ready);
  modport sink (input valid, out_red, out_green, out_blue, out_last, output ready);
endinterface

@@ hw/rtl/rgbc_ram.sv @@
// generic single-write, single-read ram with registered read data
module rgbc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hw/rtl/rgb_conv3x3_zero_pad_clamp_top.sv @@
// rgb 3x3 convolution with zero padding and 0..255 clamp, line buffers in ram
// latency: a result passes the line buffer read, window, product and column-sum registers
//   into the output fifo (pixel p completes its window at transaction p+width+1)
// throughput: one transaction per cycle; input stalls only when the 8-entry
//   result fifo plus results still in the 4-stage pipe would overflow it
// reset: registers to defaults, position, window and fifo cleared; the line
//   buffer rams are not cleared and need no clearing pass
module rgb_conv3x3_zero_pad_clamp_top (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [rgbc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [rgbc_pkg::CFG_DATA_W-1:0]  cfg_data,
  rgbc_in_if.sink                          pix_in,
  rgbc_out_if.source                       pix_out
);

  localparam int AW = rgbc_pkg::ADDR_W;
  localparam int CW = rgbc_pkg::CHAN_W;
  localparam int KB = rgbc_pkg::COEF_BITS;

  // configuration registers
  logic [rgbc_pkg::WIDTH_REG_W-1:0]  frame_width;
  logic [rgbc_pkg::HEIGHT_REG_W-1:0] frame_height;
  logic [rgbc_pkg::KERNEL_W-1:0]     kern [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= rgbc_pkg::FRAME_WIDTH_RESET;
      frame_height <= rgbc_pkg::FRAME_HEIGHT_RESET;
      kern[0]      <= '0;
      kern[1]      <= rgbc_pkg::KERNEL_MID_RESET;
      kern[2]      <= '0;
    end else if (cfg_write) begin
      case (rgbc_pkg::cfg_reg_t'(cfg_index))
        rgbc_pkg::REG_FRAME_WIDTH:   frame_width  <= cfg_data[rgbc_pkg::WIDTH_REG_W-1:0];
        rgbc_pkg::REG_FRAME_HEIGHT:  frame_height <= cfg_data[rgbc_pkg::HEIGHT_REG_W-1:0];
        rgbc_pkg::REG_KERNEL_TOP:    kern[0] <= cfg_data[rgbc_pkg::KERNEL_W-1:0];
        rgbc_pkg::REG_KERNEL_MIDDLE: kern[1] <= cfg_data[rgbc_pkg::KERNEL_W-1:0];
        rgbc_pkg::REG_KERNEL_BOTTOM: kern[2] <= cfg_data[rgbc_pkg::KERNEL_W-1:0];
        default: ;
      endcase
    end
  end

  // effective frame size
  logic [rgbc_pkg::WEFF_W-1:0] w_eff;
  logic [rgbc_pkg::ROW_W-1:0]  h_eff;

  always_comb begin
    if (frame_width == '0) begin
      w_eff = rgbc_pkg::WEFF_W'(1);
    end else if (32'(frame_width) > 32'(rgbc_pkg::MAX_WIDTH)) begin
      w_eff = rgbc_pkg::WEFF_W'(rgbc_pkg::MAX_WIDTH);
    end else begin
      w_eff = rgbc_pkg::WEFF_W'(frame_width);
    end
    if (frame_height == '0) begin
      h_eff = rgbc_pkg::ROW_W'(1);
    end else if (32'(frame_height) > 32'(rgbc_pkg::MAX_HEIGHT)) begin
      h_eff = rgbc_pkg::ROW_W'(rgbc_pkg::MAX_HEIGHT);
    end else begin
      h_eff = rgbc_pkg::ROW_W'(frame_height);
    end
  end

  // stream position and decode of the incoming transaction
  logic [AW-1:0]                 col, col_next;
  logic [rgbc_pkg::ROW_W-1:0]    row, row_next;
  logic                          in_accept;
  logic                          restart;
  logic [AW-1:0]                 c;
  logic [rgbc_pkg::ROW_W-1:0]    r;
  logic [rgbc_pkg::ROW_W:0]      h_plus1;
  logic [AW:0]                   col_inc;
  logic                          r_ge1, r_ge2;
  rgbc_pkg::tap_ctrl_t           acc_ctrl;
  logic [rgbc_pkg::PIX_W-1:0]    acc_pix;

  assign in_accept = pix_in.valid && pix_in.ready;
  assign h_plus1   = {1'b0, h_eff} + 1'b1;

  always_comb begin
    restart = ({1'b0, row} > h_plus1) || (32'(col) >= 32'(rgbc_pkg::MAX_WIDTH));
    c       = restart ? '0 : col;
    r       = restart ? '0 : row;
    r_ge1   = (r != '0);
    r_ge2   = (r >= rgbc_pkg::ROW_W'(2));

    acc_pix = '0;
    if ((pix_in.cmd == rgbc_pkg::CMD_PIXEL) && (r < h_eff)) begin
      acc_pix = {pix_in.pixel_blue, pix_in.pixel_green, pix_in.pixel_red};
    end

    if (c != '0) begin
      acc_ctrl.res        = r_ge1 && (r <= h_eff);
      acc_ctrl.left_zero  = (c == AW'(1));
      acc_ctrl.right_zero = 1'b0;
      acc_ctrl.last       = 1'b0;
    end else begin
      acc_ctrl.res        = r_ge2 && ({1'b0, r} <= h_plus1);
      acc_ctrl.left_zero  = (w_eff == rgbc_pkg::WEFF_W'(1));
      acc_ctrl.right_zero = 1'b1;
      acc_ctrl.last       = r_ge2 && ({1'b0, r} == h_plus1);
    end

    col_inc = {1'b0, c} + 1'b1;
    if (32'(col_inc) >= 32'(w_eff)) begin
      col_next = '0;
      row_next = r + 1'b1;
    end else begin
      col_next = col_inc[AW-1:0];
      row_next = r;
    end
    if (acc_ctrl.last) begin
      col_next = '0;
      row_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (in_accept) begin
      col <= col_next;
      row <= row_next;
    end
  end

  // stage 1: line buffer read data arrives, write-back and window shift
  logic                       s1_v;
  rgbc_pkg::tap_ctrl_t        s1_ctrl;
  logic [AW-1:0]              s1_addr;
  logic [rgbc_pkg::PIX_W-1:0] s1_pix;
  logic                       s1_r_ge1, s1_r_ge2;
  logic                       fwd;
  logic [rgbc_pkg::PIX_W-1:0] fwd_upper, fwd_lower;
  logic [rgbc_pkg::PIX_W-1:0] ram_upper_rd, ram_lower_rd;
  logic [rgbc_pkg::PIX_W-1:0] up_data, lo_data, top, mid;

  rgbc_ram #(.WIDTH(rgbc_pkg::PIX_W), .DEPTH(rgbc_pkg::MAX_WIDTH)) u_row_upper (
    .clk  (clk),
    .we   (s1_v),
    .waddr(s1_addr),
    .wdata(lo_data),
    .raddr(c),
    .rdata(ram_upper_rd)
  );

  rgbc_ram #(.WIDTH(rgbc_pkg::PIX_W), .DEPTH(rgbc_pkg::MAX_WIDTH)) u_row_lower (
    .clk  (clk),
    .we   (s1_v),
    .waddr(s1_addr),
    .wdata(s1_pix),
    .raddr(c),
    .rdata(ram_lower_rd)
  );

  // a read issued in the same cycle as a write to that entry sees stale data
  always_comb begin
    up_data = fwd ? fwd_upper : ram_upper_rd;
    lo_data = fwd ? fwd_lower : ram_lower_rd;
    top     = s1_r_ge2 ? up_data : '0;
    mid     = s1_r_ge1 ? lo_data : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s1_ctrl <= '0;
      fwd <= 1'b0;
    end else begin
      s1_v <= in_accept;
      s1_ctrl <= in_accept ? acc_ctrl : '0;
      fwd <= s1_v && in_accept && (c == s1_addr);
    end
    s1_addr   <= c;
    s1_pix    <= acc_pix;
    s1_r_ge1  <= r_ge1;
    s1_r_ge2  <= r_ge2;
    fwd_upper <= lo_data;
    fwd_lower <= s1_pix;
  end

  // window: index column*3 + row
  logic [rgbc_pkg::PIX_W-1:0] win [9];
  logic                       win_clr;
  rgbc_pkg::tap_ctrl_t        s2_ctrl;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 9; i++) begin
        win[i] <= '0;
      end
      win_clr <= 1'b0;
      s2_ctrl <= '0;
    end else begin
      s2_ctrl <= s1_ctrl;
      if (s1_v) begin
        for (int i = 0; i < 6; i++) begin
          win[i] <= win_clr ? '0 : win[i+3];
        end
        win[6]  <= top;
        win[7]  <= mid;
        win[8]  <= s1_pix;
        win_clr <= s1_ctrl.last;
      end
    end
  end

  // stage 2: 27 products, one multiplier per tap and channel
  logic signed [rgbc_pkg::PROD_W-1:0] prod_c [3][3][3];
  logic signed [rgbc_pkg::PROD_W-1:0] prod   [3][3][3];
  rgbc_pkg::tap_ctrl_t                s3_ctrl;

  always_comb begin
    logic signed [CW:0]   pv;
    logic signed [KB-1:0] cf;
    for (int ch = 0; ch < 3; ch++) begin
      for (int cl = 0; cl < 3; cl++) begin
        for (int rw = 0; rw < 3; rw++) begin
          pv = $signed({1'b0, win[cl*3+rw][ch*CW +: CW]});
          cf = $signed(kern[rw][cl*KB +: KB]);
          if ((cl == 0 && s2_ctrl.left_zero) || (cl == 2 && s2_ctrl.right_zero)) begin
            prod_c[ch][cl][rw] = '0;
          end else begin
            prod_c[ch][cl][rw] = rgbc_pkg::PROD_W'(pv * cf);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_ctrl <= '0;
    end else begin
      s3_ctrl <= s2_ctrl;
    end
    prod <= prod_c;
  end

  // stage 3: column sums
  logic signed [rgbc_pkg::COL_W-1:0] colsum [3][3];
  rgbc_pkg::tap_ctrl_t               s4_ctrl;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_ctrl <= '0;
    end else begin
      s4_ctrl <= s3_ctrl;
    end
    for (int ch = 0; ch < 3; ch++) begin
      for (int cl = 0; cl < 3; cl++) begin
        colsum[ch][cl] <= rgbc_pkg::COL_W'(prod[ch][cl][0])
                        + rgbc_pkg::COL_W'(prod[ch][cl][1])
                        + rgbc_pkg::COL_W'(prod[ch][cl][2]);
      end
    end
  end

  // stage 4: total, clamp, push into result fifo
  logic signed [rgbc_pkg::SUM_W-1:0] total [3];
  logic [CW-1:0]                     chan  [3];
  rgbc_pkg::out_item_t               push_item;

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      total[ch] = rgbc_pkg::SUM_W'(colsum[ch][0]) + rgbc_pkg::SUM_W'(colsum[ch][1])
                + rgbc_pkg::SUM_W'(colsum[ch][2]);
      if (total[ch][rgbc_pkg::SUM_W-1]) begin
        chan[ch] = '0;
      end else if (total[ch][rgbc_pkg::SUM_W-2:rgbc_pkg::FRAC_BITS+CW] != '0) begin
        chan[ch] = CW'(rgbc_pkg::CHAN_MAX);
      end else begin
        chan[ch] = total[ch][rgbc_pkg::FRAC_BITS +: CW];
      end
    end
    push_item.red   = chan[0];
    push_item.green = chan[1];
    push_item.blue  = chan[2];
    push_item.last  = s4_ctrl.last;
  end

  rgbc_pkg::out_item_t               fifo_mem [rgbc_pkg::FIFO_DEPTH];
  logic [rgbc_pkg::FIFO_AW-1:0]      wr_ptr, rd_ptr;
  logic [rgbc_pkg::FIFO_CW-1:0]      fifo_count;
  logic [rgbc_pkg::FIFO_CW-1:0]      inflight;
  logic                              push, pop;
  rgbc_pkg::out_item_t               head;

  assign push     = s4_ctrl.res;
  assign pop      = pix_out.valid && pix_out.ready;
  assign inflight = rgbc_pkg::FIFO_CW'(s1_ctrl.res) + rgbc_pkg::FIFO_CW'(s2_ctrl.res)
                  + rgbc_pkg::FIFO_CW'(s3_ctrl.res) + rgbc_pkg::FIFO_CW'(s4_ctrl.res);

  // credit: every result in the pipe already owns a fifo slot
  assign pix_in.ready = (fifo_count + inflight) < rgbc_pkg::FIFO_CW'(rgbc_pkg::FIFO_DEPTH);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr     <= '0;
      rd_ptr     <= '0;
      fifo_count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      fifo_count <= fifo_count + rgbc_pkg::FIFO_CW'(push) - rgbc_pkg::FIFO_CW'(pop);
    end
    if (push) begin
      fifo_mem[wr_ptr] <= push_item;
    end
  end

  assign head              = fifo_mem[rd_ptr];
  assign pix_out.valid     = (fifo_count != '0);
  assign pix_out.out_red   = head.red;
  assign pix_out.out_green = head.green;
  assign pix_out.out_blue  = head.blue;
  assign pix_out.out_last  = head.last;

  a_fifo_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push && !pop |-> fifo_count < rgbc_pkg::FIFO_CW'(rgbc_pkg::FIFO_DEPTH))
    else $error("result fifo overflow");

  a_credit_bound: assert property (@(posedge clk) disable iff (rst)
    (fifo_count + inflight) <= rgbc_pkg::FIFO_CW'(rgbc_pkg::FIFO_DEPTH))
    else $error("results in flight exceed fifo space");

  a_last_restarts: assert property (@(posedge clk) disable iff (rst)
    in_accept && acc_ctrl.last |=> (col == '0) && (row == '0))
    else $error("position not cleared after final result");

  a_fwd_has_write: assert property (@(posedge clk) disable iff (rst)
    fwd |-> s1_v && $past(s1_v))
    else $error("forwarding without a pending write");

  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    s1_v && s1_ctrl.last |=> win_clr)
    else $error("window clear not armed after final result");

endmodule

@@ verif/rgb_conv3x3_zero_pad_clamp_top_tb.sv @@
`timescale 1ns / 1ps
// self-checking testbench for the rgb 3x3 convolution block with zero padding and clamp
module rgb_conv3x3_zero_pad_clamp_top_tb;
  import rgbc_pkg::*;

  localparam int LONG_HOLD   = 300;
  localparam int SETTLE_CYC  = 8;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    cmd_t              cmd;
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } pixel_item_t;

  logic                   clk;
  logic                   rst;
  logic                   cfg_write;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  rgbc_in_if  in_bus();
  rgbc_out_if out_bus();

  rgb_conv3x3_zero_pad_clamp_top dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pix_in    (in_bus),
    .pix_out   (out_bus)
  );

  // filter state as the block should hold it
  logic [WIDTH_REG_W-1:0]  width_reg;
  logic [HEIGHT_REG_W-1:0] height_reg;
  logic [KERNEL_W-1:0]     kern [3];
  logic [PIX_W-1:0]        older_row [MAX_WIDTH];
  logic [PIX_W-1:0]        prev_row [MAX_WIDTH];
  logic [PIX_W-1:0]        taps [9];
  int unsigned             col_pos;
  int unsigned             row_pos;

  pixel_item_t pending_pixels[$];
  out_item_t   expected_pixels[$];
  pixel_item_t cur_item;

  int          send_idle_pct;
  int          recv_idle_pct;
  int          hold_token = 0;
  int          hold_seen = 0;
  int          hold_left = 0;
  int unsigned items_queued = 0;
  int unsigned items_accepted = 0;
  int unsigned results_seen = 0;
  int unsigned frames_sent = 0;
  int unsigned cfg_writes = 0;
  int unsigned err_count = 0;

  function automatic int unsigned eff_width(input logic [WIDTH_REG_W-1:0] v);
    if (v == 0) return 1;
    if (v > MAX_WIDTH) return MAX_WIDTH;
    return v;
  endfunction

  function automatic int unsigned eff_height(input logic [HEIGHT_REG_W-1:0] v);
    if (v == 0) return 1;
    if (v > MAX_HEIGHT) return MAX_HEIGHT;
    return v;
  endfunction

  function automatic logic [CHAN_W-1:0] clamp_chan(input longint acc);
    longint v;
    if (acc < 0) return '0;
    v = acc >>> FRAC_BITS;
    if (v > CHAN_MAX) return CHAN_W'(CHAN_MAX);
    return v[CHAN_W-1:0];
  endfunction

  // advance the filter by one accepted transaction, queue the pixel it completes
  function automatic void filter_pixel(input pixel_item_t it);
    int unsigned       w;
    int unsigned       h;
    int unsigned       c;
    int unsigned       r;
    logic [PIX_W-1:0]  pix;
    logic [PIX_W-1:0]  up;
    logic [PIX_W-1:0]  mid;
    logic              produce;
    logic              lz;
    logic              rz;
    logic              fin;
    logic [CHAN_W-1:0] chan [3];
    longint            acc;
    out_item_t         res;
    w = eff_width(width_reg);
    h = eff_height(height_reg);
    if (row_pos > h + 1 || col_pos >= MAX_WIDTH) begin
      row_pos = 0;
      col_pos = 0;
    end
    c = col_pos;
    r = row_pos;
    // flushes and anything past the last frame row enter as zero pixels
    pix = '0;
    if (it.cmd == CMD_PIXEL && r < h) pix = {it.blue, it.green, it.red};
    up  = (r >= 2) ? older_row[c] : '0;
    mid = (r >= 1) ? prev_row[c] : '0;
    older_row[c] = prev_row[c];
    prev_row[c]  = pix;
    for (int i = 0; i < 6; i++) taps[i] = taps[i + 3];
    taps[6] = up;
    taps[7] = mid;
    taps[8] = pix;
    // column 0 completes the right-edge pixel two rows up
    if (c >= 1) begin
      produce = (r >= 1) && (r - 1 < h);
      lz = (c == 1);
      rz = 1'b0;
      fin = 1'b0;
    end else begin
      produce = (r >= 2) && (r - 2 < h);
      lz = (w == 1);
      rz = 1'b1;
      fin = produce && (r - 2 == h - 1);
    end
    col_pos = c + 1;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos = r + 1;
    end
    if (!produce) return;
    for (int ch = 0; ch < 3; ch++) begin
      acc = 0;
      for (int j = 0; j < 3; j++) begin
        if (!((j == 0 && lz) || (j == 2 && rz))) begin
          for (int i = 0; i < 3; i++)
            acc += longint'(taps[j*3+i][ch*CHAN_W +: CHAN_W]) *
                   longint'($signed(kern[i][j*COEF_BITS +: COEF_BITS]));
        end
      end
      chan[ch] = clamp_chan(acc);
    end
    res.red   = chan[0];
    res.green = chan[1];
    res.blue  = chan[2];
    res.last  = fin;
    expected_pixels.push_back(res);
    if (fin) begin
      col_pos = 0;
      row_pos = 0;
      foreach (taps[k]) taps[k] = '0;
    end
  endfunction

  function automatic void check_field(input string name, input logic [CHAN_W-1:0] want,
                                      input logic [CHAN_W-1:0] got);
    if (want !== got) begin
      err_count++;
      if (err_count <= MAX_REPORTS)
        $display("mismatch on %s at result %0d: expected %0d, got %0d",
                 name, results_seen, want, got);
    end
  endfunction

  function automatic logic [CHAN_W-1:0] rand_chan();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      default: return CHAN_W'($urandom_range(255));
    endcase
  endfunction

  function automatic logic [KERNEL_W-1:0] rand_kernel_row();
    logic [KERNEL_W-1:0]  row;
    logic [COEF_BITS-1:0] coef;
    for (int j = 0; j < 3; j++) begin
      case ($urandom_range(5))
        0: coef = COEF_BITS'($urandom_range(16'hFFFF));
        1: coef = $urandom_range(1) ? 16'h7FFF : 16'h8000;
        2: coef = '0;
        // small signed weights, from -80 to 80
        default: coef = COEF_BITS'($urandom_range(160) - 80);
      endcase
      row[j*COEF_BITS +: COEF_BITS] = coef;
    end
    return row;
  endfunction

  // sender: offers queued pixels, updates the filter on each accepted transaction
  always @(posedge clk) begin : drive_pixels
    if (rst) begin
      in_bus.valid <= 1'b0;
    end else begin
      if (in_bus.valid && in_bus.ready) begin
        filter_pixel(cur_item);
        items_accepted++;
      end
      if (!in_bus.valid || in_bus.ready) begin
        if (pending_pixels.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          cur_item = pending_pixels.pop_front();
          in_bus.valid       <= 1'b1;
          in_bus.cmd         <= cur_item.cmd;
          in_bus.pixel_red   <= cur_item.red;
          in_bus.pixel_green <= cur_item.green;
          in_bus.pixel_blue  <= cur_item.blue;
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  // receiver: checks each result against the oldest expected pixel
  always @(posedge clk) begin : watch_results
    out_item_t got;
    out_item_t want;
    if (rst) begin
      out_bus.ready <= 1'b0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        got.red   = out_bus.out_red;
        got.green = out_bus.out_green;
        got.blue  = out_bus.out_blue;
        got.last  = out_bus.out_last;
        results_seen++;
        if (expected_pixels.size() == 0) begin
          err_count++;
          if (err_count <= MAX_REPORTS)
            $display("unexpected result %0d: r %0d g %0d b %0d last %0d",
                     results_seen, got.red, got.green, got.blue, got.last);
        end else begin
          want = expected_pixels.pop_front();
          check_field("out_red", want.red, got.red);
          check_field("out_green", want.green, got.green);
          check_field("out_blue", want.blue, got.blue);
          check_field("out_last", CHAN_W'(want.last), CHAN_W'(got.last));
        end
      end
      if (hold_token != hold_seen) begin
        hold_seen = hold_token;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  task automatic push_pixel(input cmd_t cmd, input logic [CHAN_W-1:0] red,
                            input logic [CHAN_W-1:0] green, input logic [CHAN_W-1:0] blue);
    pixel_item_t it;
    it.cmd   = cmd;
    it.red   = red;
    it.green = green;
    it.blue  = blue;
    pending_pixels.push_back(it);
    items_queued++;
  endtask

  task automatic wait_drained();
    while (items_accepted != items_queued || expected_pixels.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      REG_FRAME_WIDTH:   width_reg  = val[WIDTH_REG_W-1:0];
      REG_FRAME_HEIGHT:  height_reg = val[HEIGHT_REG_W-1:0];
      REG_KERNEL_TOP:    kern[0] = val;
      REG_KERNEL_MIDDLE: kern[1] = val;
      REG_KERNEL_BOTTOM: kern[2] = val;
      default: ;
    endcase
    cfg_writes++;
  endtask

  // registers change only once the previous frame has fully drained
  task automatic set_frame(input logic [WIDTH_REG_W-1:0] wr, input logic [HEIGHT_REG_W-1:0] hr,
                           input logic [KERNEL_W-1:0] kt, input logic [KERNEL_W-1:0] km,
                           input logic [KERNEL_W-1:0] kb);
    wait_drained();
    repeat (SETTLE_CYC) @(posedge clk);
    write_reg(REG_FRAME_WIDTH, wr);
    write_reg(REG_FRAME_HEIGHT, hr);
    write_reg(REG_KERNEL_TOP, kt);
    write_reg(REG_KERNEL_MIDDLE, km);
    write_reg(REG_KERNEL_BOTTOM, kb);
    @(posedge clk);
    cfg_write <= 1'b0;
    @(negedge clk);
    frames_sent++;
  endtask

  // one full frame plus its flush tail, with stray flushes and stray pixels mixed in
  task automatic queue_frame(input int pause_at);
    int unsigned w;
    int unsigned n_pix;
    int unsigned total;
    w = eff_width(width_reg);
    n_pix = w * eff_height(height_reg);
    total = n_pix + w + 1;
    for (int k = 0; k < total; k++) begin
      if (k == pause_at) wait_drained();
      if (k < n_pix)
        push_pixel(($urandom_range(19) == 0) ? CMD_FLUSH : CMD_PIXEL,
                   rand_chan(), rand_chan(), rand_chan());
      else
        push_pixel(($urandom_range(6) == 0) ? CMD_PIXEL : CMD_FLUSH,
                   rand_chan(), rand_chan(), rand_chan());
    end
  endtask

  task automatic random_frames(input int unsigned budget, input bit with_hold,
                               input bit with_pause);
    int unsigned             spent;
    int unsigned             w;
    int unsigned             h;
    int unsigned             sel;
    logic [WIDTH_REG_W-1:0]  wr;
    logic [HEIGHT_REG_W-1:0] hr;
    bit                      first;
    spent = 0;
    first = 1'b1;
    while (spent < budget) begin
      if (first && (with_hold || with_pause)) begin
        w = 24;
        h = 10;
      end else begin
        sel = $urandom_range(99);
        if (sel < 50) w = $urandom_range(6, 1);
        else if (sel < 85) w = $urandom_range(24, 7);
        else w = $urandom_range(64, 25);
        h = (w <= 8) ? $urandom_range(12, 1) : $urandom_range(5, 1);
      end
      wr = w;
      hr = h;
      if (w == 1 && $urandom_range(1)) wr = '0;
      if (h == 1 && $urandom_range(1)) hr = '0;
      set_frame(wr, hr, rand_kernel_row(), rand_kernel_row(), rand_kernel_row());
      if (first && with_hold) hold_token++;
      queue_frame((first && with_pause) ? int'(w * h / 2) : -1);
      spent += w * h + w + 1;
      first = 1'b0;
    end
  endtask

  initial begin : clock_gen
    clk = 1'b0;
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = REG_FRAME_WIDTH;
    cfg_data = '0;
    in_bus.valid = 1'b0;
    in_bus.cmd = CMD_PIXEL;
    in_bus.pixel_red = '0;
    in_bus.pixel_green = '0;
    in_bus.pixel_blue = '0;
    out_bus.ready = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin : stimulus
    width_reg  = FRAME_WIDTH_RESET;
    height_reg = FRAME_HEIGHT_RESET;
    kern[0] = '0;
    kern[1] = KERNEL_MID_RESET;
    kern[2] = '0;
    foreach (older_row[i]) older_row[i] = '0;
    foreach (prev_row[i]) prev_row[i] = '0;
    foreach (taps[i]) taps[i] = '0;
    col_pos = 0;
    row_pos = 0;
    send_idle_pct = 31;
    recv_idle_pct = 79;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // single-column frame: only the middle column of the kernel is used
    set_frame(1, 1, {3{16'h0100}}, {16'h0100, 16'h0200, 16'h0100}, {3{16'h0100}});
    push_pixel(CMD_PIXEL, 8'd255, 8'd0, 8'd128);
    push_pixel(CMD_FLUSH, 8'd0, 8'd0, 8'd0);
    push_pixel(CMD_FLUSH, 8'hFF, 8'hFF, 8'hFF);

    // lanes written right, middle, left; coefficient extremes and negatives
    set_frame(3, 2, {16'h0080, 16'h0000, 16'h8000}, {16'h0040, 16'h7FFF, 16'hFF00},
              {16'h0100, 16'hFFFF, 16'h0000});
    push_pixel(CMD_PIXEL, 8'd255, 8'd255, 8'd255);
    push_pixel(CMD_PIXEL, 8'd0, 8'd0, 8'd0);
    push_pixel(CMD_PIXEL, 8'd1, 8'd128, 8'd254);
    push_pixel(CMD_FLUSH, 8'd77, 8'd88, 8'd99);  // flush inside the frame is a zero pixel
    push_pixel(CMD_PIXEL, 8'd255, 8'd0, 8'd255);
    push_pixel(CMD_PIXEL, 8'd7, 8'd8, 8'd9);
    push_pixel(CMD_PIXEL, 8'd200, 8'd100, 8'd50);  // pixel after the frame acts as flush
    push_pixel(CMD_FLUSH, 8'd0, 8'd0, 8'd0);
    push_pixel(CMD_FLUSH, 8'd0, 8'd0, 8'd0);
    push_pixel(CMD_PIXEL, 8'd255, 8'd255, 8'd255);

    // fractional weights: truncation and negative sums clamping to zero
    set_frame(2, 1, '0, {16'h0001, 16'h0180, 16'hFF80}, '0);
    push_pixel(CMD_PIXEL, 8'd255, 8'd1, 8'd0);
    push_pixel(CMD_PIXEL, 8'd3, 8'd254, 8'd255);
    push_pixel(CMD_FLUSH, 8'd0, 8'd0, 8'd0);
    push_pixel(CMD_FLUSH, 8'd0, 8'd0, 8'd0);
    push_pixel(CMD_FLUSH, 8'd0, 8'd0, 8'd0);

    random_frames(400, 1'b0, 1'b0);
    // width register above the maximum, height register zero: one full-width row
    set_frame(11'h7FF, 13'h0000, rand_kernel_row(), rand_kernel_row(), rand_kernel_row());
    queue_frame(-1);

    send_idle_pct = 79;
    recv_idle_pct = 31;
    random_frames(400, 1'b0, 1'b1);
    // width register zero, height register all ones: one column of maximum height
    set_frame(11'h000, 13'h1FFF, rand_kernel_row(), rand_kernel_row(), rand_kernel_row());
    queue_frame(-1);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_frames(400, 1'b1, 1'b0);

    wait_drained();
    repeat (4 * SETTLE_CYC) @(posedge clk);
    $display("tb: %0d pixel transactions over %0d frames, %0d filtered pixels checked",
             items_accepted, frames_sent, results_seen);
    $display("tb: %0d register writes, frame sizes from 1x1 to 1024 wide and 4096 high",
             cfg_writes);
    if (err_count == 0 && expected_pixels.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
